### rtl/chd_pkg.sv
// Shared constants for the compass heading block: CORDIC angle table and output scaling.
`timescale 1ns / 1ps
`default_nettype none
package chd_pkg;

  // Fractional guard bits added below the axis readings.
  localparam int GUARD_BITS = 8;

  // Length of the rotation angle table.
  localparam int TABLE_LEN = 24;

  // Binary angle width: a full turn is 2^ANGLE_WIDTH.
  localparam int ANGLE_WIDTH = 32;

  // Heading output width and tenths of a degree in one full turn.
  localparam int HEADING_WIDTH = 12;
  localparam logic [HEADING_WIDTH-1:0] TENTHS_PER_TURN = 12'd3600;

  // Half a turn, the start angle for vectors in the left half-plane.
  localparam logic [ANGLE_WIDTH-1:0] HALF_TURN = 32'h8000_0000;

  // Rounding offset of one half in the binary angle scaled to tenths.
  localparam logic [ANGLE_WIDTH+HEADING_WIDTH-1:0] ROUND_HALF = 44'h000_8000_0000;

  // round(atan(2^-i) / (2*pi) * 2^32) for each rotation step.
  localparam logic [ANGLE_WIDTH-1:0] STEP_ANGLE [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage
`default_nettype wire

### rtl/compass_heading_atan2_top.sv
// Top level of the compass heading block: input stage, CORDIC cell chain, output scaling.
//
// Takes one item of two signed axis readings (axis_x_i, axis_y_i) and returns
// one item holding the heading atan2(y, x) in tenths of a degree, 0 to 3599,
// counterclockwise from +X. Both channels use valid and stall; an item moves
// at a rising edge where valid is high and stall is low.
// From acceptance to the result on the output, an item passes one input
// stage, one register per CORDIC cell (min(CORDIC_STEPS, 24) cells), one
// multiplier stage and the output register. Throughput is one item per
// cycle while the output is not stalled; every stage has its own valid bit,
// so the chain keeps filling while a result waits, and in_stall_o rises
// only once every stage holds an item and the output is stalled.
// Reset clears all valid bits; no result is shown until an item passes through.
// While out_stall_i is high the output item holds steady.
`timescale 1ns / 1ps
`default_nettype none
module compass_heading_atan2_top
  import chd_pkg::*;
#(
  parameter int CORDIC_STEPS = 16,
  parameter int AXIS_WIDTH   = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [AXIS_WIDTH-1:0]  axis_x_i,
  input  wire logic signed [AXIS_WIDTH-1:0]  axis_y_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [HEADING_WIDTH-1:0]           heading_tenths_o
);

  localparam int NSTEPS    = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  // Sign, fold headroom and CORDIC gain above the guarded reading.
  localparam int VEC_WIDTH = AXIS_WIDTH + GUARD_BITS + 3;

  logic                        valid_s [NSTEPS+1];
  logic                        stall_s [NSTEPS+1];
  logic signed [VEC_WIDTH-1:0] x_s     [NSTEPS+1];
  logic signed [VEC_WIDTH-1:0] y_s     [NSTEPS+1];
  logic [ANGLE_WIDTH-1:0]      z_s     [NSTEPS+1];
  logic                        zero_s  [NSTEPS+1];

  chd_prep #(
    .AXIS_WIDTH (AXIS_WIDTH),
    .VEC_WIDTH  (VEC_WIDTH)
  ) u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .stall_o  (in_stall_o),
    .axis_x_i (axis_x_i),
    .axis_y_i (axis_y_i),
    .valid_o  (valid_s[0]),
    .stall_i  (stall_s[0]),
    .x_o      (x_s[0]),
    .y_o      (y_s[0]),
    .z_o      (z_s[0]),
    .zero_o   (zero_s[0])
  );

  // Chain of rotation cells, one per CORDIC step.
  for (genvar i = 0; i < NSTEPS; i++) begin : g_cell
    chd_cell #(
      .VEC_WIDTH (VEC_WIDTH),
      .STEP      (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[i]),
      .stall_o (stall_s[i]),
      .x_i     (x_s[i]),
      .y_i     (y_s[i]),
      .z_i     (z_s[i]),
      .zero_i  (zero_s[i]),
      .valid_o (valid_s[i+1]),
      .stall_i (stall_s[i+1]),
      .x_o     (x_s[i+1]),
      .y_o     (y_s[i+1]),
      .z_o     (z_s[i+1]),
      .zero_o  (zero_s[i+1])
    );
  end

  chd_scale u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (valid_s[NSTEPS]),
    .stall_o   (stall_s[NSTEPS]),
    .z_i       (z_s[NSTEPS]),
    .zero_i    (zero_s[NSTEPS]),
    .valid_o   (out_valid_o),
    .stall_i   (out_stall_i),
    .heading_o (heading_tenths_o)
  );

  // A delivered heading always lies inside one turn.
  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (heading_tenths_o < TENTHS_PER_TURN))
    else $error("heading out of range");

  // The input side backs up only while a result waits at a stalled output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled output");

  // The first and last chain stages hold items whenever the input is stalled.
  a_chain_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (valid_s[0] && valid_s[NSTEPS]))
    else $error("input stalled with a bubble in the chain");

endmodule
`default_nettype wire

### rtl/chd_prep.sv
// Input stage: scales the reading and folds the left half-plane onto the right.
`timescale 1ns / 1ps
`default_nettype none
module chd_prep
  import chd_pkg::*;
#(
  parameter int AXIS_WIDTH = 16,
  parameter int VEC_WIDTH  = 27
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  output logic                               stall_o,
  input  wire logic signed [AXIS_WIDTH-1:0]  axis_x_i,
  input  wire logic signed [AXIS_WIDTH-1:0]  axis_y_i,
  output logic                               valid_o,
  input  wire logic                          stall_i,
  output logic signed [VEC_WIDTH-1:0]        x_o,
  output logic signed [VEC_WIDTH-1:0]        y_o,
  output logic [ANGLE_WIDTH-1:0]             z_o,
  output logic                               zero_o
);

  logic                        valid_q;
  logic signed [VEC_WIDTH-1:0] x_q, y_q, x_d, y_d, x_ext, y_ext;
  logic [ANGLE_WIDTH-1:0]      z_q, z_d;
  logic                        zero_q, zero_d;

  // The stage holds its item only while the next stage stalls.
  assign stall_o = valid_q && stall_i;

  // Sign-extend, add guard bits, and negate the vector when x is negative.
  always_comb begin
    x_ext  = VEC_WIDTH'(axis_x_i) <<< GUARD_BITS;
    y_ext  = VEC_WIDTH'(axis_y_i) <<< GUARD_BITS;
    zero_d = (axis_x_i == '0) && (axis_y_i == '0);
    if (axis_x_i[AXIS_WIDTH-1]) begin
      x_d = -x_ext;
      y_d = -y_ext;
      z_d = HALF_TURN;
    end else begin
      x_d = x_ext;
      y_d = y_ext;
      z_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      zero_q <= zero_d;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign zero_o  = zero_q;

endmodule
`default_nettype wire

### rtl/chd_cell.sv
// One CORDIC vectoring cell: a single rotation step with a fixed shift and angle.
`timescale 1ns / 1ps
`default_nettype none
module chd_cell
  import chd_pkg::*;
#(
  parameter int VEC_WIDTH = 27,
  parameter int STEP      = 0
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  output logic                             stall_o,
  input  wire logic signed [VEC_WIDTH-1:0] x_i,
  input  wire logic signed [VEC_WIDTH-1:0] y_i,
  input  wire logic [ANGLE_WIDTH-1:0]      z_i,
  input  wire logic                        zero_i,
  output logic                             valid_o,
  input  wire logic                        stall_i,
  output logic signed [VEC_WIDTH-1:0]      x_o,
  output logic signed [VEC_WIDTH-1:0]      y_o,
  output logic [ANGLE_WIDTH-1:0]           z_o,
  output logic                             zero_o
);

  logic                        valid_q;
  logic signed [VEC_WIDTH-1:0] x_q, y_q, x_d, y_d, xs, ys;
  logic [ANGLE_WIDTH-1:0]      z_q, z_d;
  logic                        zero_q;

  assign stall_o = valid_q && stall_i;

  // Rotate toward the x axis; the arithmetic shift rounds toward minus infinity.
  always_comb begin
    xs = x_i >>> STEP;
    ys = y_i >>> STEP;
    if (!y_i[VEC_WIDTH-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + STEP_ANGLE[STEP];
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - STEP_ANGLE[STEP];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      zero_q <= zero_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign zero_o  = zero_q;

  // After the half-plane fold the x component never goes negative.
  a_x_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> !x_q[VEC_WIDTH-1])
    else $error("cordic cell holds a negative x component");

endmodule
`default_nettype wire

### rtl/chd_scale.sv
// Output stages: scale the binary angle to tenths of a degree, round and wrap.
`timescale 1ns / 1ps
`default_nettype none
module chd_scale
  import chd_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  output logic                           stall_o,
  input  wire logic [ANGLE_WIDTH-1:0]    z_i,
  input  wire logic                      zero_i,
  output logic                           valid_o,
  input  wire logic                      stall_i,
  output logic [HEADING_WIDTH-1:0]       heading_o
);

  localparam int PROD_WIDTH = ANGLE_WIDTH + HEADING_WIDTH;

  logic                     mul_valid_q, out_valid_q, mul_stall;
  logic [PROD_WIDTH-1:0]    prod_q, sum;
  logic                     zero_q;
  logic [HEADING_WIDTH-1:0] heading_q, heading_d;

  assign mul_stall = mul_valid_q && stall_i && out_valid_q;
  assign stall_o   = mul_stall;

  // Multiply stage: angle times tenths per turn.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (!mul_stall) begin
      mul_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!mul_stall && valid_i) begin
      prod_q <= PROD_WIDTH'(z_i) * PROD_WIDTH'(TENTHS_PER_TURN);
      zero_q <= zero_i;
    end
  end

  // Round to nearest tenth; a full turn wraps to zero, as does the zero vector.
  always_comb begin
    sum = prod_q + ROUND_HALF;
    heading_d = sum[PROD_WIDTH-1:ANGLE_WIDTH];
    if (zero_q || (heading_d >= TENTHS_PER_TURN)) begin
      heading_d = '0;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!(out_valid_q && stall_i)) begin
      out_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!(out_valid_q && stall_i) && mul_valid_q) begin
      heading_q <= heading_d;
    end
  end

  assign valid_o   = out_valid_q;
  assign heading_o = heading_q;

endmodule
`default_nettype wire
